/* rtl/bav_pkg.sv */
// Shared types and constants of the box average filter.
`timescale 1ns / 1ps
`default_nettype none
package bav_pkg;

  // Configuration register fields
  localparam int unsigned KreqW  = 4;
  localparam int unsigned DimW   = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PixW   = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;

  // Configuration reset values
  localparam logic [KreqW-1:0] KREQ_RESET = 4'd3;
  localparam logic [DimW-1:0]  DIM_RESET  = 11'd512;

  // Input kinds carried on tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Control sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_PROC  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_LAST  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

endpackage
`default_nettype wire

/* rtl/bav_line_mem.sv */
// Line store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bav_line_mem #(
  parameter int unsigned Depth = 15375,
  parameter int unsigned AddrW = 14
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AddrW-1:0]           waddr_i,
  input  wire logic [bav_pkg::PixW-1:0]   wdata_i,
  input  wire logic [AddrW-1:0]           raddr_i,
  output logic      [bav_pkg::PixW-1:0]   rdata_o
);

  logic [bav_pkg::PixW-1:0] mem [Depth];

  // Write pixel
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read: data follows the address in the next cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/bav_divider.sv */
// Division of the window sum by the kernel area through a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none
module bav_divider #(
  parameter int unsigned SumW  = 16,
  parameter int unsigned AreaW = 8,
  parameter int unsigned KW    = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [SumW-1:0]          dividend_i,
  input  wire logic [KW-1:0]            kernel_i,
  output logic                          done_o,
  output logic [bav_pkg::PixW-1:0]      quotient_o
);

  // floor(x / d) equals (x * ceil(2^RecS / d)) >> RecS for every x below 2^SumW
  // as long as d stays below 2^AreaW
  localparam int unsigned RecS  = SumW + AreaW;
  localparam int unsigned RecW  = RecS + 1;
  localparam int unsigned ProdW = SumW + RecW;
  localparam int unsigned NumK  = 2 ** (KW - 1);

  logic [RecW-1:0]          recip_tab [NumK];
  logic                     busy_q, done_q;
  logic [SumW-1:0]          dvd_q;
  logic [RecW-1:0]          rec_q;
  logic [ProdW-1:0]         prod;
  logic [bav_pkg::PixW-1:0] quo_q;

  // Reciprocal of k*k for each odd kernel size k = 2*i+1
  for (genvar gi = 0; gi < NumK; gi++) begin : g_recip
    localparam int unsigned Area = (2 * gi + 1) * (2 * gi + 1);
    assign recip_tab[gi] = RecW'(((64'd1 << RecS) + 64'(Area) - 64'd1) / 64'(Area));
  end

  // Track the two pipeline steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // Latch the operands, then hold the scaled product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rec_q <= recip_tab[kernel_i[KW-1:1]];
    end
    if (busy_q) begin
      quo_q <= prod[RecS +: bav_pkg::PixW];
    end
  end

  assign prod       = ProdW'(dvd_q) * ProdW'(rec_q);
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

/* rtl/box_average_filter.sv */
// Top level of the streaming box average filter.
// Latency: an output leaves h*W+h inputs after its own pixel (h = kernel/2); after the
// transfer that releases it the sequencer runs PROC, k*k reads in READ, LAST and the divide,
// then loads the output register in OUT once it is free (SETUP comes first at frame start).
// Flow: input is taken only in IDLE, so no new item is accepted until the last is done; an
// output costs k*k reads through the single line store read port plus a reciprocal divide.
// Reset: asynchronous, active low; config returns to kernel 3, 512x512.
`timescale 1ns / 1ps
`default_nettype none
module box_average_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_KERNEL = 15
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [bav_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bav_pkg::DimW-1:0]      cfg_wdata_i,
  // Input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [7:0] pixel_in
  input  wire logic                          s_axis_tuser_i,  // [0] op
  // Output stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,  // [7:0] pixel_out
  output logic                               m_axis_tlast_o   // frame_end
);

  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1);
  localparam int unsigned NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned DlyMax = (MAX_KERNEL / 2) * MAX_WIDTH + MAX_KERNEL / 2;
  localparam int unsigned PW     = $clog2(MAX_WIDTH * MAX_HEIGHT + DlyMax + 2);
  localparam int unsigned Depth  = MAX_KERNEL * MAX_WIDTH + MAX_KERNEL;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned ARW    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int unsigned SUMW   = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int unsigned SW     = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_KERNEL) + 1;
  localparam int unsigned KMaxOdd = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;

  bav_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [bav_pkg::KreqW-1:0] kreq_q;
  logic [bav_pkg::DimW-1:0]  fw_q, fh_q;

  // Frame state
  logic              active_q, active_d;
  logic [KW-1:0]     k_q, k_d, half_q, half_d;
  logic [WW-1:0]     w_q, w_d;
  logic [HW-1:0]     h_q, h_d;
  logic [NW-1:0]     n_q, n_d;
  logic [PW-1:0]     delay_q, delay_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic [AW-1:0]     out_addr_q, out_addr_d;
  logic [HW-1:0]     out_row_q, out_row_d;
  logic [WW-1:0]     out_col_q, out_col_d;
  logic              op_q, op_d;
  logic [7:0]        px_q, px_d;

  // Window walk
  logic [KW-1:0]          ri_q, ri_d, ci_q, ci_d;
  logic signed [SW-1:0]   rr_q, rr_d, cc_q, cc_d;
  logic [AW-1:0]          rd_addr_q, rd_addr_d, row_base_q, row_base_d;
  logic                   pend_q, pend_d, inb_q, inb_d;
  logic [SUMW-1:0]        sum_q, sum_d;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic [7:0]        out_px_q, out_px_d;
  logic              out_fe_q, out_fe_d;

  // Normalized frame parameters
  logic [KW-1:0]     k_norm;
  logic [WW-1:0]     w_clamp;
  logic [HW-1:0]     h_clamp;

  logic              mem_we;
  logic [7:0]        mem_rdata;
  logic              div_start, div_done;
  logic [7:0]        quotient;
  logic [SUMW-1:0]   sum_in;
  logic [SUMW-1:0]   sum_final;
  logic              in_acc;
  logic              fe;
  logic              inb_now;
  logic [AW:0]       base_step;
  logic [AW:0]       base_sub;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kreq_q <= bav_pkg::KREQ_RESET;
      fw_q   <= bav_pkg::DIM_RESET;
      fh_q   <= bav_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bav_pkg::CFG_KERNEL: kreq_q <= cfg_wdata_i[bav_pkg::KreqW-1:0];
        bav_pkg::CFG_WIDTH:  fw_q   <= cfg_wdata_i;
        bav_pkg::CFG_HEIGHT: fh_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Normalize kernel and clamp frame size
  always_comb begin
    logic [bav_pkg::KreqW-1:0] kodd;
    kodd = kreq_q[0] ? kreq_q : kreq_q - 1'b1;
    if (kreq_q < 4'd3) begin
      k_norm = KW'(1);
    end else if (32'(kodd) > KMaxOdd) begin
      k_norm = KW'(KMaxOdd);
    end else begin
      k_norm = KW'(kodd);
    end
    if (fw_q == '0) begin
      w_clamp = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_clamp = HW'(1);
    end else if (32'(fh_q) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(fh_q);
    end
  end

  assign s_axis_tready_o = (state_q == bav_pkg::S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Window bounds and address stepping
  assign inb_now   = !rr_q[SW-1] && !cc_q[SW-1] &&
                     (rr_q < SW'(h_q)) && (cc_q < SW'(w_q));
  assign base_step = {1'b0, row_base_q} + (AW + 1)'(w_q);
  assign base_sub  = {1'b0, out_addr_q} - (AW + 1)'(delay_q);
  assign sum_in    = (pend_q && inb_q) ? sum_q + SUMW'(mem_rdata) : sum_q;
  assign sum_final = sum_in;
  assign fe        = (out_row_q == h_q - 1'b1) && (out_col_q == w_q - 1'b1);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    k_d        = k_q;
    half_d     = half_q;
    w_d        = w_q;
    h_d        = h_q;
    n_d        = n_q;
    delay_d    = delay_q;
    pos_d      = pos_q;
    wr_addr_d  = wr_addr_q;
    out_addr_d = out_addr_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    op_d       = op_q;
    px_d       = px_q;
    ri_d       = ri_q;
    ci_d       = ci_q;
    rr_d       = rr_q;
    cc_d       = cc_q;
    rd_addr_d  = rd_addr_q;
    row_base_d = row_base_q;
    pend_d     = 1'b0;
    inb_d      = inb_q;
    sum_d      = sum_q;
    out_vld_d  = out_vld_q;
    out_px_d   = out_px_q;
    out_fe_d   = out_fe_q;
    mem_we     = 1'b0;
    div_start  = 1'b0;

    // Drop the output once transferred
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      bav_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d = s_axis_tuser_i;
          px_d = s_axis_tdata_i;
          if (active_q) begin
            state_d = bav_pkg::S_PROC;
          end else if (s_axis_tuser_i == bav_pkg::OP_PIXEL) begin
            active_d   = 1'b1;
            k_d        = k_norm;
            half_d     = k_norm >> 1;
            w_d        = w_clamp;
            h_d        = h_clamp;
            pos_d      = '0;
            wr_addr_d  = '0;
            out_addr_d = '0;
            out_row_d  = '0;
            out_col_d  = '0;
            state_d    = bav_pkg::S_SETUP;
          end
        end
      end
      bav_pkg::S_SETUP: begin
        n_d     = NW'(w_q) * NW'(h_q);
        delay_d = PW'(half_q) * PW'(w_q) + PW'(half_q);
        state_d = bav_pkg::S_PROC;
      end
      bav_pkg::S_PROC: begin
        if ((pos_q < PW'(n_q)) && (op_q == bav_pkg::OP_DRAIN)) begin
          state_d = bav_pkg::S_IDLE;
        end else begin
          if (pos_q < PW'(n_q)) begin
            mem_we    = 1'b1;
            wr_addr_d = (wr_addr_q == AW'(Depth - 1)) ? '0 : wr_addr_q + 1'b1;
          end
          pos_d = pos_q + 1'b1;
          if (pos_q < delay_q) begin
            state_d = bav_pkg::S_IDLE;
          end else begin
            // Start the window walk at its top-left corner
            ri_d       = '0;
            ci_d       = '0;
            rr_d       = SW'(out_row_q) - SW'(half_q);
            cc_d       = SW'(out_col_q) - SW'(half_q);
            row_base_d = base_sub[AW] ? AW'(base_sub + (AW + 1)'(Depth))
                                      : AW'(base_sub);
            rd_addr_d  = row_base_d;
            sum_d      = '0;
            state_d    = bav_pkg::S_READ;
          end
        end
      end
      bav_pkg::S_READ: begin
        // Issue one read, accumulate the previous one
        pend_d = 1'b1;
        inb_d  = inb_now;
        sum_d  = sum_in;
        if (ci_q == k_q - 1'b1) begin
          ci_d       = '0;
          ri_d       = ri_q + 1'b1;
          cc_d       = SW'(out_col_q) - SW'(half_q);
          rr_d       = rr_q + 1'b1;
          row_base_d = (base_step >= (AW + 1)'(Depth))
                       ? AW'(base_step - (AW + 1)'(Depth)) : AW'(base_step);
          rd_addr_d  = row_base_d;
          if (ri_q == k_q - 1'b1) begin
            state_d = bav_pkg::S_LAST;
          end
        end else begin
          ci_d      = ci_q + 1'b1;
          cc_d      = cc_q + 1'b1;
          rd_addr_d = (rd_addr_q == AW'(Depth - 1)) ? '0 : rd_addr_q + 1'b1;
        end
      end
      bav_pkg::S_LAST: begin
        sum_d     = sum_in;
        div_start = 1'b1;
        state_d   = bav_pkg::S_DIV;
      end
      bav_pkg::S_DIV: begin
        if (div_done) begin
          state_d = bav_pkg::S_OUT;
        end
      end
      bav_pkg::S_OUT: begin
        // Load the output register once it is free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_px_d   = quotient;
          out_fe_d   = fe;
          out_addr_d = (out_addr_q == AW'(Depth - 1)) ? '0 : out_addr_q + 1'b1;
          if (out_col_q == w_q - 1'b1) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
          if (fe) begin
            active_d = 1'b0;
          end
          state_d = bav_pkg::S_IDLE;
        end
      end
      default: state_d = bav_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bav_pkg::S_IDLE;
      active_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  // Payload and frame registers
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    half_q     <= half_d;
    w_q        <= w_d;
    h_q        <= h_d;
    n_q        <= n_d;
    delay_q    <= delay_d;
    pos_q      <= pos_d;
    wr_addr_q  <= wr_addr_d;
    out_addr_q <= out_addr_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    op_q       <= op_d;
    px_q       <= px_d;
    ri_q       <= ri_d;
    ci_q       <= ci_d;
    rr_q       <= rr_d;
    cc_q       <= cc_d;
    rd_addr_q  <= rd_addr_d;
    row_base_q <= row_base_d;
    inb_q      <= inb_d;
    sum_q      <= sum_d;
    out_px_q   <= out_px_d;
    out_fe_q   <= out_fe_d;
  end

  bav_line_mem #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr_q),
    .wdata_i (px_q),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  bav_divider #(
    .SumW  (SUMW),
    .AreaW (ARW),
    .KW    (KW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_final),
    .kernel_i   (k_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_px_q;
  assign m_axis_tlast_o  = out_fe_q;

endmodule
`default_nettype wire
